FILE: src/rcsd_pkg.sv
// rcsd_pkg: shared types and constants of the radio channel scaler.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package rcsd_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int CH_W         = 4;
  localparam int RAW_W        = 11;
  localparam int VAL_W        = 10;
  localparam int DIFF_W       = RAW_W + 1;
  localparam int NUM_W        = RAW_W + VAL_W;
  localparam int DIV_STEPS    = VAL_W;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 10;

  localparam logic [VAL_W-1:0] SCALE_MAX    = VAL_W'(1000);
  localparam logic [VAL_W-1:0] SAFETY_LIMIT = VAL_W'(500);
  localparam logic [VAL_W-1:0] DEADBAND_RST = VAL_W'(5);
  localparam logic [CH_W-1:0]  SAFETY_RST   = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADBAND  = 2'd0,
    CFG_SAFETY_CH = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [RAW_W-1:0] raw_value;
    logic [RAW_W-1:0] min_endpoint;
    logic [RAW_W-1:0] max_endpoint;
    logic             failsafe;
  } in_beat_t;

  typedef struct packed {
    logic [CH_W-1:0]  out_channel;
    logic [VAL_W-1:0] value;
    logic             safety_off;
  } out_beat_t;

  // Partial division state handed from cell to cell.
  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic             failsafe;
    logic             zero;      // equal endpoints or negative quotient
    logic             sat;       // quotient at or above full scale
    logic [RAW_W-1:0] divisor;
    logic [RAW_W-1:0] rem;
    logic [VAL_W-1:0] num_lo;    // numerator bits still to shift in
    logic [VAL_W-1:0] quo;
  } div_beat_t;

endpackage

`default_nettype wire

FILE: src/rcsd_prep.sv
// rcsd_prep: first pipeline stage; endpoint differences, case flags and the
// scaled numerator. Depends on rcsd_pkg.
`default_nettype none

module rcsd_prep
  import rcsd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      up_valid,
  output logic           up_ready,
  input  wire in_beat_t  up_data,
  output logic           dn_valid,
  input  wire logic      dn_ready,
  output div_beat_t      dn_data
);

  logic              valid_r;
  div_beat_t         data_r;
  div_beat_t         data_nxt;
  logic [DIFF_W-1:0] span;
  logic [DIFF_W-1:0] offs;
  logic [RAW_W-1:0]  abs_span;
  logic [RAW_W-1:0]  abs_offs;
  logic [NUM_W-1:0]  numer;
  logic              span_zero;
  logic              sign_diff;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    offs      = {1'b0, up_data.raw_value} - {1'b0, up_data.min_endpoint};
    span      = {1'b0, up_data.max_endpoint} - {1'b0, up_data.min_endpoint};
    abs_offs  = offs[DIFF_W-1] ? RAW_W'(-offs) : offs[RAW_W-1:0];
    abs_span  = span[DIFF_W-1] ? RAW_W'(-span) : span[RAW_W-1:0];
    span_zero = (span == '0);
    sign_diff = offs[DIFF_W-1] != span[DIFF_W-1];
    numer     = NUM_W'(abs_offs) * NUM_W'(SCALE_MAX);

    data_nxt.channel  = up_data.channel;
    data_nxt.failsafe = up_data.failsafe;
    data_nxt.zero     = span_zero || sign_diff;
    data_nxt.sat      = abs_offs >= abs_span;
    data_nxt.divisor  = abs_span;
    // Quotient fits VAL_W bits on the divide path, so the top bits start below the divisor.
    data_nxt.rem      = numer[NUM_W-1:VAL_W];
    data_nxt.num_lo   = numer[VAL_W-1:0];
    data_nxt.quo      = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/rcsd_div_cell.sv
// rcsd_div_cell: one restoring division step, one quotient bit per cell.
// Depends on rcsd_pkg.
`default_nettype none

module rcsd_div_cell
  import rcsd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      up_valid,
  output logic           up_ready,
  input  wire div_beat_t up_data,
  output logic           dn_valid,
  input  wire logic      dn_ready,
  output div_beat_t      dn_data
);

  logic             valid_r;
  div_beat_t        data_r;
  div_beat_t        data_nxt;
  logic [RAW_W:0]   trial;
  logic             fits;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    trial    = {up_data.rem, up_data.num_lo[VAL_W-1]};
    fits     = trial >= {1'b0, up_data.divisor};
    data_nxt = up_data;
    data_nxt.rem    = fits ? RAW_W'(trial - {1'b0, up_data.divisor}) : trial[RAW_W-1:0];
    data_nxt.num_lo = {up_data.num_lo[VAL_W-2:0], 1'b0};
    data_nxt.quo    = {up_data.quo[VAL_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/rcsd_out_stage.sv
// rcsd_out_stage: saturation, deadband hold, per-channel store and the
// output register. Depends on rcsd_pkg.
`default_nettype none

module rcsd_out_stage
  import rcsd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [VAL_W-1:0] deadband,
  input  wire logic [CH_W-1:0]  safety_ch,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire div_beat_t        up_data,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output out_beat_t             dn_data
);

  logic                    valid_r;
  out_beat_t               data_r;
  out_beat_t               data_nxt;
  logic [VAL_W-1:0]        prev_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] above_r;
  logic [NUM_CHANNELS-1:0] above_nxt;
  logic [VAL_W-1:0]        prev;
  logic [VAL_W-1:0]        scaled;
  logic [VAL_W-1:0]        result;
  logic                    hold;
  logic                    load;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;
  assign load     = up_valid && up_ready;

  always_comb begin
    prev = prev_r[up_data.channel];
    // Equal endpoints and negative quotients win over saturation.
    if (up_data.zero) begin
      scaled = '0;
    end else if (up_data.sat) begin
      scaled = SCALE_MAX;
    end else begin
      scaled = up_data.quo;
    end
    // Strictly inside prev +/- deadband; sums kept one bit wider, no negatives.
    hold = ({1'b0, scaled} + {1'b0, deadband} > {1'b0, prev}) &&
           ({1'b0, scaled} < {1'b0, prev} + {1'b0, deadband});
    if (up_data.failsafe) begin
      result = '0;
    end else if (hold) begin
      result = prev;
    end else begin
      result = scaled;
    end

    above_nxt = above_r;
    above_nxt[up_data.channel] = result > SAFETY_LIMIT;

    data_nxt.out_channel = up_data.channel;
    data_nxt.value       = result;
    data_nxt.safety_off  = above_nxt[safety_ch];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      above_r <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        prev_r[i] <= '0;
      end
    end else begin
      if (up_ready) begin
        valid_r <= up_valid;
      end
      if (load) begin
        above_r                 <= above_nxt;
        prev_r[up_data.channel] <= result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/rc_channel_scale_deadband.sv
// rc_channel_scale_deadband: top level of the radio channel scaler.
// Depends on rcsd_pkg, rcsd_prep, rcsd_div_cell and rcsd_out_stage.
//
//   channel  | direction | handshake           | beat
//   ---------+-----------+---------------------+----------------------------
//   in_      | in        | in_valid / in_stall | in_data   (in_beat_t)
//   out_     | out       | out_valid/out_stall | out_data  (out_beat_t)
//   cfg_     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One beat enters per cycle when nothing backs up; the pipeline holds
// one prep stage, a chain of ten divider cells (one quotient bit per cell)
// and the output register. The divider chain sets the latency, not the rate.
// Reset clears every pipeline valid, zeros the per-channel store and loads
// deadband 5 and safety channel 0. out_stall holds the output register;
// each stage still takes a beat while it or its successor has room, so
// in_stall rises only once every stage holds a beat.
`default_nettype none

module rc_channel_scale_deadband
  import rcsd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_beat_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_beat_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [VAL_W-1:0]     deadband_r;
  logic [CH_W-1:0]      safety_ch_r;
  logic                 prep_ready;
  logic [DIV_STEPS:0]   cell_vld;
  logic [DIV_STEPS:0]   cell_rdy;
  div_beat_t            cell_data [DIV_STEPS+1];

  // Registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r  <= DEADBAND_RST;
      safety_ch_r <= SAFETY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEADBAND:  deadband_r  <= cfg_data[VAL_W-1:0];
        CFG_SAFETY_CH: safety_ch_r <= cfg_data[CH_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  assign in_stall = !prep_ready;

  // Offsets, flags and the scaled numerator.
  rcsd_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (prep_ready),
    .up_data  (in_data),
    .dn_valid (cell_vld[0]),
    .dn_ready (cell_rdy[0]),
    .dn_data  (cell_data[0])
  );

  // Divider chain: each cell shifts in one numerator bit and keeps one quotient bit.
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
    rcsd_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cell_vld[g]),
      .up_ready (cell_rdy[g]),
      .up_data  (cell_data[g]),
      .dn_valid (cell_vld[g+1]),
      .dn_ready (cell_rdy[g+1]),
      .dn_data  (cell_data[g+1])
    );
  end

  // Saturate, apply the deadband against the stored value, update the store.
  rcsd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .deadband  (deadband_r),
    .safety_ch (safety_ch_r),
    .up_valid  (cell_vld[DIV_STEPS]),
    .up_ready  (cell_rdy[DIV_STEPS]),
    .up_data   (cell_data[DIV_STEPS]),
    .dn_valid  (out_valid),
    .dn_ready  (!out_stall),
    .dn_data   (out_data)
  );

endmodule

`default_nettype wire

FILE: src/rcsd_checker.sv
// rcsd_checker: port-level assertions for rc_channel_scale_deadband,
// bound to the top level. Depends on rcsd_pkg.
`default_nettype none

module rcsd_checker
  import rcsd_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire out_beat_t             out_data
);

  // Output register empties on reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Scaled values never leave full scale.
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.value <= SCALE_MAX)
    else $error("value above full scale");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // A result beat leaves only when taken.
  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(!out_stall))
    else $error("result beat dropped");

endmodule

bind rc_channel_scale_deadband rcsd_checker u_rcsd_checker (.*);

`default_nettype wire

FILE: tb/sv/rcsd_beat_checker.sv
// rcsd_beat_checker: watches the sample, result and register channels of the
// radio channel scaler, predicts every result beat and compares it.
// Depends on rcsd_pkg for beat types, register codes and scale constants.
`default_nettype none

module rcsd_beat_checker
  import rcsd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire in_beat_t              in_data,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire out_beat_t             out_data,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending
);

  localparam int REPORT_MAX = 10;

  logic [VAL_W-1:0] stored_value [NUM_CHANNELS];
  logic [VAL_W-1:0] deadband;
  logic [CH_W-1:0]  safety_ch;
  out_beat_t        expected_beats [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Linear map onto 0..full scale; division truncates toward zero.
  function automatic int map_to_scale(in_beat_t b);
    int span;
    int q;
    span = int'(b.max_endpoint) - int'(b.min_endpoint);
    if (span == 0) return 0;
    q = (int'(b.raw_value) - int'(b.min_endpoint)) * int'(SCALE_MAX) / span;
    if (q < 0) q = 0;
    if (q > int'(SCALE_MAX)) q = int'(SCALE_MAX);
    return q;
  endfunction

  // Scale, apply the hold band, update the channel store, read the safety flag.
  function automatic out_beat_t scale_with_deadband(in_beat_t b);
    int        prev;
    int        v;
    int        db;
    logic      in_range;
    out_beat_t r;
    in_range = int'(b.channel) < NUM_CHANNELS;
    prev     = in_range ? int'(stored_value[b.channel]) : 0;
    db       = int'(deadband);
    if (b.failsafe) begin
      v = 0;
    end else begin
      v = map_to_scale(b);
      if (v < prev + db && v > prev - db) v = prev;
    end
    if (in_range) stored_value[b.channel] = VAL_W'(v);
    r.out_channel = b.channel;
    r.value       = VAL_W'(v);
    r.safety_off  = (int'(safety_ch) < NUM_CHANNELS) &&
                    (stored_value[safety_ch] > SAFETY_LIMIT);
    return r;
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      foreach (stored_value[i]) stored_value[i] = '0;
      deadband  = DEADBAND_RST;
      safety_ch = SAFETY_RST;
      expected_beats.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEADBAND:  deadband  = cfg_data[VAL_W-1:0];
          CFG_SAFETY_CH: safety_ch = cfg_data[CH_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected result beat: ch=%0d value=%0d safety_off=%0b",
                     out_data.out_channel, out_data.value, out_data.safety_off);
        end else begin
          want = expected_beats.pop_front();
          if (out_data.out_channel !== want.out_channel ||
              out_data.value       !== want.value ||
              out_data.safety_off  !== want.safety_off) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("result mismatch: expected ch=%0d value=%0d safety_off=%0b, %s",
                       want.out_channel, want.value, want.safety_off,
                       $sformatf("got ch=%0d value=%0d safety_off=%0b",
                                 out_data.out_channel, out_data.value,
                                 out_data.safety_off));
          end
        end
      end
      if (in_valid && !in_stall) expected_beats.push_back(scale_with_deadband(in_data));
    end
    pending = expected_beats.size();
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// tb_top: stimulus, clock, reset and verdict for the radio channel scaler.
// Depends on rcsd_pkg, rc_channel_scale_deadband and rcsd_beat_checker.
`default_nettype none

module tb_top;
  import rcsd_pkg::*;

  localparam int RANDOM_PHASES   = 8;
  localparam int BEATS_PER_PHASE = 154;
  // Leave a margin before register writes and the verdict.
  localparam int SETTLE_CYCLES   = 24;
  localparam int RUN_LIMIT       = 3_000_000;
  localparam int RAW_MAX         = (1 << RAW_W) - 1;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_beat_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int                    fail_count;
  int                    pending;

  int          burst_left = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          stall_tick = 0;
  in_beat_t    last_sent [NUM_CHANNELS];

  rc_channel_scale_deadband DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rcsd_beat_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  // Hard stop in case a handshake never completes.
  initial begin
    #(RUN_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver back-pressure: hold one mode for a random stretch, then switch.
  // The no-stall mode gives long stretches where results drain freely.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 160);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_tick % 3 == 0);
    endcase
  end

  function automatic in_beat_t make_beat(int ch, int raw, int lo, int hi, bit fs);
    in_beat_t b;
    b.channel      = CH_W'(ch);
    b.raw_value    = RAW_W'(raw);
    b.min_endpoint = RAW_W'(lo);
    b.max_endpoint = RAW_W'(hi);
    b.failsafe     = fs;
    return b;
  endfunction

  // Pick a random sample. Most are well-calibrated channels or small moves
  // around the channel's last sample, so the hold band gets exercised; the
  // rest are failsafe, equal or reversed endpoints, and raw noise.
  function automatic in_beat_t random_beat();
    in_beat_t b;
    int       ch;
    int       pick;
    int       lo;
    int       hi;
    int       raw;
    int       jitter;
    ch   = $urandom_range(0, NUM_CHANNELS - 1);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      lo = $urandom_range(0, 600);
      hi = $urandom_range(1400, RAW_MAX);
      b  = make_beat(ch, $urandom_range(0, RAW_MAX), lo, hi, 1'b0);
    end else if (pick < 60) begin
      b      = last_sent[ch];
      jitter = $urandom_range(1, 24);
      raw    = int'(b.raw_value) + $urandom_range(0, 2 * jitter) - jitter;
      if (raw < 0) raw = 0;
      if (raw > RAW_MAX) raw = RAW_MAX;
      b.raw_value = RAW_W'(raw);
      b.failsafe  = 1'b0;
    end else if (pick < 70) begin
      b = make_beat(ch, $urandom_range(0, RAW_MAX), $urandom_range(0, RAW_MAX),
                    $urandom_range(0, RAW_MAX), 1'b1);
    end else if (pick < 78) begin
      lo = $urandom_range(0, RAW_MAX);
      b  = make_beat(ch, $urandom_range(0, RAW_MAX), lo, lo, 1'b0);
    end else if (pick < 88) begin
      hi = $urandom_range(0, RAW_MAX - 1);
      lo = $urandom_range(hi + 1, RAW_MAX);
      b  = make_beat(ch, $urandom_range(0, RAW_MAX), lo, hi, 1'b0);
    end else begin
      b = make_beat(ch, $urandom_range(0, RAW_MAX), $urandom_range(0, RAW_MAX),
                    $urandom_range(0, RAW_MAX), 1'($urandom_range(0, 1)));
    end
    last_sent[ch] = b;
    return b;
  endfunction

  // Send one sample beat. Work in bursts: when a burst runs out, drop valid
  // for a random gap (sometimes none) before the next beat. Hold the beat
  // until the scaler takes it, then return at the next falling edge.
  task automatic send_beat(in_beat_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_data  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid, wait for every expected result, then let the pipe settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Keep cfg_valid high across back-to-back writes; the caller drops it.
  task automatic write_register(cfg_reg_e idx, logic [CFG_DATA_W-1:0] d);
    cfg_index <= idx;
    cfg_data  <= d;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  initial begin
    int db;
    int sc;
    foreach (last_sent[i]) last_sent[i] = make_beat(i, 1024, 172, 1811, 1'b0);

    // Hold reset, then release it at a falling edge.
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under reset settings: deadband 5, safety channel 0.
    send_beat(make_beat(0, 0, 0, 0, 1'b0));          // all zero, equal endpoints
    send_beat(make_beat(0, 1024, 0, 2047, 1'b0));    // 500: safety not yet off
    send_beat(make_beat(0, 1026, 0, 2047, 1'b0));    // 501 held at 500
    send_beat(make_beat(0, 1040, 0, 2047, 1'b0));    // 508 leaves band, safety off
    send_beat(make_beat(0, 1035, 0, 2047, 1'b0));    // 505 held at 508
    send_beat(make_beat(0, 1030, 0, 2047, 1'b0));    // 503 on lower band edge: taken
    send_beat(make_beat(1, 0, 0, 2047, 1'b0));       // bottom of scale
    send_beat(make_beat(2, 2047, 0, 2047, 1'b0));    // top of scale
    send_beat(make_beat(3, 2047, 2047, 2047, 1'b0)); // equal endpoints at top
    send_beat(make_beat(4, 100, 172, 1811, 1'b0));   // raw below min saturates to 0
    send_beat(make_beat(5, 2000, 172, 1811, 1'b0));  // raw above max saturates
    send_beat(make_beat(6, 1000, 1811, 172, 1'b0));  // reversed endpoints, mid
    send_beat(make_beat(7, 100, 1811, 172, 1'b0));   // reversed, saturates high
    send_beat(make_beat(8, 2047, 1811, 172, 1'b0));  // reversed, clamps at 0
    send_beat(make_beat(9, 2047, 2047, 0, 1'b0));    // reversed full span, zero
    send_beat(make_beat(0, 2047, 0, 2047, 1'b1));    // failsafe clears the store
    send_beat(make_beat(15, 2047, 2047, 2047, 1'b1)); // every input bit high
    send_beat(make_beat(0, 2047, 0, 2047, 1'b0));    // back to full scale
    send_beat(make_beat(0, 2037, 0, 2047, 1'b0));    // 995 on lower band edge: taken
    send_beat(make_beat(0, 2047, 0, 2047, 1'b0));    // 1000 on band edge: taken
    send_beat(make_beat(0, 2044, 0, 2047, 1'b0));    // 998 held at 1000

    // Random phases: rewrite both registers while idle, starting with the
    // extremes, then mostly narrow bands so that holds stay common.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin db = 0;    sc = NUM_CHANNELS - 1; end
        1: begin db = int'(SCALE_MAX); sc = 0; end
        2: begin db = 1;    sc = $urandom_range(0, NUM_CHANNELS - 1); end
        default: begin
          db = ($urandom_range(0, 4) == 0) ? $urandom_range(0, int'(SCALE_MAX))
                                           : $urandom_range(2, 40);
          sc = $urandom_range(0, NUM_CHANNELS - 1);
        end
      endcase
      drain_results();
      write_register(CFG_DEADBAND, CFG_DATA_W'(db));
      write_register(CFG_SAFETY_CH, CFG_DATA_W'(sc));
      cfg_valid <= 1'b0;
      for (int n = 0; n < BEATS_PER_PHASE; n++) send_beat(random_beat());
    end

    drain_results();
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
